// ===== sv/sdum_pkg.sv =====
// Shared types, codes and constants of the stepper driver datagram master.
// Holds the CRC-8 byte update used by the front and the back.
// No dependencies.
package sdum_pkg;

   localparam logic [7:0]  SYNC_BYTE         = 8'h55;
   localparam logic [7:0]  CRC_POLY          = 8'h07;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd1042;
   localparam logic [16:0] ELAPSED_MAX       = 17'h1FFFF;
   localparam logic [2:0]  RESPONSE_BYTES    = 3'd7;
   localparam logic [2:0]  VALUE_FIRST_BYTE  = 3'd3;
   localparam int unsigned JOB_DEPTH_DEFAULT = 4;

   localparam int unsigned CSR_ADDR_W    = 3;
   localparam int unsigned CSR_DATA_W    = 32;
   localparam logic        CSR_IDX_RESPONSE_TIMEOUT = 1'b0;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_RX_BYTE = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TIMEOUT   = 2'd1,
      ST_CRC_ERROR = 2'd2,
      ST_BUSY      = 2'd3
   } status_type;

   typedef enum logic {
      KIND_TRANSMIT   = 1'b0,
      KIND_COMPLETION = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      JOB_WRITE_FRAME = 2'd0,
      JOB_READ_FRAME  = 2'd1,
      JOB_COMPLETION  = 2'd2
   } job_kind_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  node_address;
      logic [6:0]  register_index;
      logic [31:0] write_value;
      logic [7:0]  received_byte;
   } req_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  transmit_byte;
      logic        last_of_frame;
      status_type  status;
      logic [31:0] read_value;
   } rsp_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   node_address;
      logic [6:0]   register_index;
      logic [31:0]  value;
      status_type   status;
   } job_type;

   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic [7:0] b;
      logic       top;
      c = crc;
      b = data;
      for (int k = 0; k < 8; k++) begin
         top = c[7];
         c   = {c[6:0], 1'b0};
         if (top ^ b[0]) begin
            c = c ^ CRC_POLY;
         end
         b = {1'b0, b[7:1]};
      end
      return c;
   endfunction

endpackage

// ===== sv/sdum_front.sv =====
// Front end: takes commands, line bytes and ticks, tracks the pending read
// and turns commands and read endings into jobs for the back end. Depends on sdum_pkg.
module sdum_front import sdum_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        item_accept,
   input  req_type     item,
   input  logic [15:0] response_timeout,
   output logic        job_push,
   output job_type     job
);

   logic        awaiting_ff, awaiting_in;
   logic [2:0]  count_ff, count_in;
   logic [7:0]  crc_ff, crc_in;
   logic [31:0] value_ff, value_in;
   logic [16:0] elapsed_ff, elapsed_in;
   logic [16:0] elapsed_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         count_ff    <= '0;
         crc_ff      <= '0;
         value_ff    <= '0;
         elapsed_ff  <= '0;
      end else begin
         awaiting_ff <= awaiting_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         value_ff    <= value_in;
         elapsed_ff  <= elapsed_in;
      end
   end

   always_comb begin
      awaiting_in = awaiting_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      value_in    = value_ff;
      elapsed_in  = elapsed_ff;
      elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 17'd1;
      job_push            = 1'b0;
      job.kind            = JOB_COMPLETION;
      job.node_address    = item.node_address;
      job.register_index  = item.register_index;
      job.value           = '0;
      job.status          = ST_OK;
      if (item_accept) begin
         unique case (item.operation)
            OP_WRITE, OP_READ: begin
               job_push = 1'b1;
               if (awaiting_ff) begin
                  job.status = ST_BUSY;
               end else if (item.operation == OP_WRITE) begin
                  job.kind  = JOB_WRITE_FRAME;
                  job.value = item.write_value;
               end else begin
                  job.kind    = JOB_READ_FRAME;
                  awaiting_in = 1'b1;
                  count_in    = '0;
                  crc_in      = '0;
                  value_in    = '0;
                  elapsed_in  = '0;
               end
            end
            OP_RX_BYTE: begin
               if (awaiting_ff) begin
                  if (count_ff != RESPONSE_BYTES) begin
                     crc_in   = crc_feed(crc_ff, item.received_byte);
                     count_in = count_ff + 3'd1;
                     if (count_ff >= VALUE_FIRST_BYTE) begin
                        value_in = {value_ff[23:0], item.received_byte};
                     end
                  end else begin
                     job_push    = 1'b1;
                     awaiting_in = 1'b0;
                     count_in    = '0;
                     if (item.received_byte == crc_ff) begin
                        job.value = value_ff;
                     end else begin
                        job.status = ST_CRC_ERROR;
                     end
                  end
               end
            end
            OP_TICK: begin
               if (awaiting_ff) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc > {1'b0, response_timeout}) begin
                     job_push    = 1'b1;
                     job.status  = ST_TIMEOUT;
                     awaiting_in = 1'b0;
                     count_in    = '0;
                  end
               end
            end
         endcase
      end
   end

endmodule

// ===== sv/sdum_job_queue.sv =====
// Short job queue between front and back end, register based.
// Depends on sdum_pkg for the job type.
module sdum_job_queue import sdum_pkg::*; #(
   parameter int unsigned DEPTH = JOB_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head_job,
   output logic    empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/sdum_back.sv =====
// Back end: walks the head job one result per cycle while the result register is
// empty or popped, builds frame bytes and their CRC, and holds the result register. Depends on sdum_pkg.
module sdum_back import sdum_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output rsp_type rsp_data,
   output logic    rsp_empty,
   input  logic    rsp_pop
);

   logic [2:0] idx_ff, idx_in;
   logic [7:0] crc_ff, crc_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       advance, last;
   logic [7:0] frame_byte;

   assign rsp_data  = rsp_ff;
   assign rsp_empty = !rsp_valid_ff;
   assign advance   = job_valid && (!rsp_valid_ff || rsp_pop);
   assign job_pop   = advance && last;

   always_comb begin
      frame_byte = crc_ff;
      last       = 1'b0;
      unique case (job.kind)
         JOB_WRITE_FRAME: begin
            unique case (idx_ff)
               3'd0: frame_byte = SYNC_BYTE;
               3'd1: frame_byte = job.node_address;
               3'd2: frame_byte = {1'b1, job.register_index};
               3'd3: frame_byte = job.value[31:24];
               3'd4: frame_byte = job.value[23:16];
               3'd5: frame_byte = job.value[15:8];
               3'd6: frame_byte = job.value[7:0];
               3'd7: last = 1'b1;
            endcase
         end
         JOB_READ_FRAME: begin
            unique case (idx_ff)
               3'd0: frame_byte = SYNC_BYTE;
               3'd1: frame_byte = job.node_address;
               3'd2: frame_byte = {1'b0, job.register_index};
               default: last = 1'b1;
            endcase
         end
         default: last = 1'b1;
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (job.kind == JOB_WRITE_FRAME || job.kind == JOB_READ_FRAME) begin
            rsp_in.result_kind   = KIND_TRANSMIT;
            rsp_in.transmit_byte = frame_byte;
            rsp_in.last_of_frame = last;
            rsp_in.status        = ST_OK;
            rsp_in.read_value    = '0;
         end else begin
            rsp_in.result_kind   = KIND_COMPLETION;
            rsp_in.transmit_byte = '0;
            rsp_in.last_of_frame = 1'b0;
            rsp_in.status        = job.status;
            rsp_in.read_value    = job.value;
         end
         if (last) begin
            idx_in = '0;
            crc_in = '0;
         end else begin
            idx_in = idx_ff + 3'd1;
            crc_in = crc_feed(crc_ff, frame_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ===== sv/stepper_driver_uart_datagram_master_unit.sv =====
// Top level of the stepper driver datagram master: front end, job queue,
// back end and the timeout register. Depends on sdum_pkg and all sdum_ modules.
//
// Request side is a queue input: req_data is taken when req_push is high and
// req_full is low. Commands give a transmit frame (8 bytes for a write, 4 for
// a read) or a busy completion; line bytes and ticks only matter while a read
// is pending and then may give one completion.
// Result side is a queue output: rsp_data is valid while rsp_empty is low and
// is taken when rsp_pop is high. The first result of an item is registered in
// the job queue and then in the result register; the back end gives one
// result per cycle while rsp_pop keeps up, so a write gives 8 results, a read 4
// and a completion 1. That result per cycle from the back end sets the throughput;
// the front takes an item per cycle while the job queue has room.
// When rsp_pop stays low the back end holds, the job queue fills and
// req_full rises; nothing is lost. Reset empties both sides, clears the
// pending read and sets response_timeout to 1042. The CSR port holds one
// register, response_timeout, at byte address 0.
module stepper_driver_uart_datagram_master_unit import sdum_pkg::*; #(
   parameter int unsigned JOB_DEPTH = JOB_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  logic                  req_push,
   output logic                  req_full,
   output rsp_type               rsp_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [15:0] timeout_ff, timeout_in;
   logic        csr_write, csr_hit;
   logic        item_accept;
   logic        job_push, job_full, job_empty, job_pop;
   job_type     front_job, head_job;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_RESPONSE_TIMEOUT);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {16'b0, timeout_ff} : '0;
   assign timeout_in = (csr_write && csr_hit) ? csr_pwdata[15:0] : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign req_full    = job_full;
   assign item_accept = req_push && !req_full;

   sdum_front u_front (
      .clock            (clock),
      .reset            (reset),
      .item_accept      (item_accept),
      .item             (req_data),
      .response_timeout (timeout_ff),
      .job_push         (job_push),
      .job              (front_job)
   );

   sdum_job_queue #(
      .DEPTH (JOB_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (job_full),
      .pop      (job_pop),
      .head_job (head_job),
      .empty    (job_empty)
   );

   sdum_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!job_empty),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

`ifndef SYNTHESIS
   a_no_job_overflow : assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("job pushed into a full queue");

   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result visible right after reset");

   a_last_on_transmit : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.last_of_frame) |-> rsp_data.result_kind == KIND_TRANSMIT)
      else $error("frame end flag on a completion");

   a_value_only_on_ok : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != ST_OK) |-> rsp_data.read_value == '0)
      else $error("read value on a failed completion");
`endif

endmodule

// ===== tb/testbench.sv =====
// Testbench for stepper_driver_uart_datagram_master_unit: directed and random datagram
// traffic, checked transfer by transfer against a datagram tracker with its own state.
// Depends on sdum_pkg and the unit's RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sdum_pkg::*;

   class datagram_tracker;
      rsp_type     pending_results[$];
      int unsigned errors;
      logic [15:0] timeout_limit;
      logic        read_pending;
      logic [3:0]  rx_count;
      logic [7:0]  rx_crc;
      logic [31:0] rx_value;
      logic [16:0] tick_count;

      function new();
         errors        = 0;
         timeout_limit = TIMEOUT_RESET;
         read_pending  = 1'b0;
         rx_count      = '0;
         rx_crc        = '0;
         rx_value      = '0;
         tick_count    = '0;
      endfunction

      static function logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
         logic [7:0] c;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            c = (c[7] ^ data[i]) ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
         end
         return c;
      endfunction

      function void add_byte(logic [7:0] b, logic last);
         rsp_type r;
         r               = '0;
         r.result_kind   = KIND_TRANSMIT;
         r.transmit_byte = b;
         r.last_of_frame = last;
         r.status        = ST_OK;
         pending_results.push_back(r);
      endfunction

      function void add_completion(status_type s, logic [31:0] v);
         rsp_type r;
         r             = '0;
         r.result_kind = KIND_COMPLETION;
         r.status      = s;
         r.read_value  = v;
         pending_results.push_back(r);
      endfunction

      // Returns 0 when the block ignores the request.
      function bit note_request(req_type q);
         logic [7:0] frame[$];
         logic [7:0] crc;
         case (q.operation)
            OP_WRITE, OP_READ: begin
               if (read_pending) begin
                  add_completion(ST_BUSY, '0);
                  return 1'b1;
               end
               frame.push_back(SYNC_BYTE);
               frame.push_back(q.node_address);
               frame.push_back({(q.operation == OP_WRITE), q.register_index});
               if (q.operation == OP_WRITE) begin
                  frame.push_back(q.write_value[31:24]);
                  frame.push_back(q.write_value[23:16]);
                  frame.push_back(q.write_value[15:8]);
                  frame.push_back(q.write_value[7:0]);
               end else begin
                  read_pending = 1'b1;
                  rx_count     = '0;
                  rx_crc       = '0;
                  rx_value     = '0;
                  tick_count   = '0;
               end
               crc = '0;
               foreach (frame[i]) begin
                  crc = crc8_update(crc, frame[i]);
                  add_byte(frame[i], 1'b0);
               end
               add_byte(crc, 1'b1);
            end
            OP_RX_BYTE: begin
               if (!read_pending) return 1'b0;
               if (rx_count < RESPONSE_BYTES) begin
                  rx_crc = crc8_update(rx_crc, q.received_byte);
                  if (rx_count >= VALUE_FIRST_BYTE) rx_value = {rx_value[23:0], q.received_byte};
                  rx_count++;
               end else begin
                  if (q.received_byte == rx_crc) add_completion(ST_OK, rx_value);
                  else add_completion(ST_CRC_ERROR, '0);
                  read_pending = 1'b0;
                  rx_count     = '0;
               end
            end
            default: begin
               if (!read_pending) return 1'b0;
               if (tick_count != ELAPSED_MAX) tick_count++;
               if (tick_count > timeout_limit) begin
                  add_completion(ST_TIMEOUT, '0);
                  read_pending = 1'b0;
                  rx_count     = '0;
               end
            end
         endcase
         return 1'b1;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $error("%s: expected %h, got %h", name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $error("unexpected transfer: kind %0d byte %h status %0d", got.result_kind,
                   got.transmit_byte, got.status);
            return;
         end
         want = pending_results.pop_front();
         compare_field("result_kind", want.result_kind, got.result_kind);
         compare_field("transmit_byte", want.transmit_byte, got.transmit_byte);
         compare_field("last_of_frame", want.last_of_frame, got.last_of_frame);
         compare_field("status", want.status, got.status);
         compare_field("read_value", want.read_value, got.read_value);
      endfunction
   endclass

   localparam int unsigned CYCLE_LIMIT = 200000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   req_type               req_data = '0;
   logic                  req_push = 1'b0;
   logic                  req_full;
   rsp_type               rsp_data;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   datagram_tracker tracker;
   bit              steady = 1'b0;
   int unsigned     hold_cycles = 0;
   int unsigned     cycle_count = 0;
   int unsigned     effective_items = 0;
   logic [15:0]     timeout_steps [6] = '{16'd20, 16'd1, 16'hFFFF, 16'd6, 16'd0, 16'd12};

   stepper_driver_uart_datagram_master_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .req_push   (req_push),
      .req_full   (req_full),
      .rsp_data   (rsp_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   always @(negedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= steady || ($urandom_range(99) >= 23);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) tracker.check_result(rsp_data);
   end

   function automatic req_type make_item(op_type op);
      req_type q;
      q.operation      = op;
      q.node_address   = 8'($urandom);
      q.register_index = 7'($urandom);
      q.write_value    = $urandom;
      q.received_byte  = 8'($urandom);
      return q;
   endfunction

   function automatic req_type pack_request(op_type op, logic [7:0] node, logic [6:0] reg_idx,
                                            logic [31:0] value, logic [7:0] rx);
      req_type q;
      q.operation      = op;
      q.node_address   = node;
      q.register_index = reg_idx;
      q.write_value    = value;
      q.received_byte  = rx;
      return q;
   endfunction

   task automatic send_item(input req_type item);
      while (!steady && $urandom_range(99) < 23) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_data <= item;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (tracker.note_request(item)) effective_items++;
   endtask

   // Sends up to eight response bytes with ticks mixed in; the eighth is the CRC.
   task automatic send_reply(input logic [7:0] body [7], input bit corrupt,
                             input int unsigned sent, input int unsigned ticks);
      logic [7:0]  reply [8];
      logic [7:0]  crc;
      int unsigned left;
      req_type     q;
      crc  = '0;
      left = ticks;
      for (int k = 0; k < 7; k++) begin
         reply[k] = body[k];
         crc      = datagram_tracker::crc8_update(crc, body[k]);
      end
      reply[7] = corrupt ? (crc ^ 8'($urandom_range(255, 1))) : crc;
      for (int k = 0; k < sent; k++) begin
         if (left != 0 && $urandom_range(1)) begin
            send_item(make_item(OP_TICK));
            left--;
         end
         q               = make_item(OP_RX_BYTE);
         q.received_byte = reply[k];
         send_item(q);
      end
   endtask

   task automatic read_exchange(input bit corrupt, input bit starve);
      logic [7:0]  body [7];
      int unsigned ticks;
      send_item(make_item(OP_READ));
      if ($urandom_range(99) < 15) send_item(make_item(op_type'($urandom_range(1))));
      for (int k = 0; k < 7; k++) begin
         body[k] = (k == 0 && $urandom_range(1)) ? SYNC_BYTE : 8'($urandom);
      end
      ticks = (tracker.timeout_limit > 3) ? $urandom_range(3) : ($urandom_range(9) == 0);
      send_reply(body, corrupt, starve ? $urandom_range(7) : 8, ticks);
      if (starve) repeat (tracker.timeout_limit + 1) send_item(make_item(OP_TICK));
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_response_timeout(input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * CSR_IDX_RESPONSE_TIMEOUT);
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.timeout_limit = data[15:0];
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {16'h0, data[15:0]}) begin
         tracker.errors++;
         $error("response_timeout: expected %h, got %h", {16'h0, data[15:0]}, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      int unsigned goal;
      int unsigned pick;
      tracker = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, idle drops, busy rejects, good and bad response CRC
      send_item(pack_request(OP_WRITE, 8'h00, 7'h00, 32'h0000_0000, 8'h00));
      send_item(pack_request(OP_WRITE, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF));
      send_item(pack_request(OP_TICK, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF));
      send_item(pack_request(OP_RX_BYTE, 8'h00, 7'h00, 32'h0, 8'h55));
      send_item(pack_request(OP_READ, 8'h12, 7'h7F, 32'hFFFF_FFFF, 8'h00));
      send_item(pack_request(OP_WRITE, 8'h34, 7'h01, 32'h1234_5678, 8'h00));
      send_item(pack_request(OP_READ, 8'h56, 7'h02, 32'h0, 8'h00));
      send_item(pack_request(OP_TICK, 8'h00, 7'h00, 32'h0, 8'h00));
      send_reply('{8'h55, 8'h12, 8'h7F, 8'hFF, 8'h00, 8'hA5, 8'h5A}, 1'b0, 8, 0);
      send_item(pack_request(OP_READ, 8'hFF, 7'h00, 32'h0, 8'hFF));
      send_reply('{8'h55, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h7E, 8'hC3}, 1'b1, 8, 0);
      wait_all_results();

      foreach (timeout_steps[p]) begin
         set_response_timeout({16'($urandom), timeout_steps[p]});
         steady = (p == 2);
         if (p == 0) begin
            // receiver backs off while writes keep coming, so the input stalls
            hold_cycles = 300;
            repeat (16) send_item(make_item(OP_WRITE));
         end
         goal = effective_items + 60;
         while (effective_items < goal) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
               send_item(make_item(OP_WRITE));
            end else if (pick < 85) begin
               read_exchange($urandom_range(99) < 20,
                             tracker.timeout_limit <= 64 && $urandom_range(99) < 10);
            end else begin
               repeat ($urandom_range(4, 1)) send_item(make_item(op_type'($urandom_range(3))));
            end
         end
         wait_all_results();
      end
      steady = 1'b0;

      if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/sdum_pkg.sv
sv/sdum_front.sv
sv/sdum_job_queue.sv
sv/sdum_back.sv
sv/stepper_driver_uart_datagram_master_unit.sv
tb/testbench.sv
